@@ src/bsps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and codes for the bounded stable priority stack.
// No dependencies; every other file imports this package.
package bsps_pkg;

   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OCC_W = 7;
   localparam int ID_W  = 16;
   localparam int QTY_W = 32;
   localparam int OP_W  = 2;
   localparam int ST_W  = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic        [ID_W-1:0]  id;
      logic signed [QTY_W-1:0] qty;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } shift_ctl_type;

endpackage

@@ src/bsps_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with operation and entry payload.
// Depends on bsps_pkg.
interface bsps_req_if;
   import bsps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic        [OP_W-1:0]  operation;
   logic        [ID_W-1:0]  entry_id;
   logic signed [QTY_W-1:0] entry_qty;

   modport source (output valid, operation, entry_id, entry_qty, input ready);
   modport sink   (input valid, operation, entry_id, entry_qty, output ready);
endinterface

@@ src/bsps_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: valid/ready handshake with head entry, status and occupancy.
// Depends on bsps_pkg.
interface bsps_rsp_if;
   import bsps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic        [ID_W-1:0]  head_id;
   logic signed [QTY_W-1:0] head_qty;
   logic        [ST_W-1:0]  status;
   logic        [OCC_W-1:0] occupancy;

   modport source (output valid, head_id, head_qty, status, occupancy, input ready);
   modport sink   (input valid, head_id, head_qty, status, occupancy, output ready);
endinterface

@@ src/bsps_cell.sv @@
`timescale 1ns / 1ps
// One slot of the ordered chain: holds one entry, takes the new entry or a
// neighbor's entry on insert and pop. Depends on bsps_pkg.
module bsps_cell (
   input  logic                    clock,
   input  bsps_pkg::shift_ctl_type ctl,
   input  bsps_pkg::entry_type     new_entry,
   input  bsps_pkg::entry_type     prev_entry,
   input  bsps_pkg::entry_type     next_entry,
   input  logic                    prev_keep,
   input  logic                    occupied,
   output bsps_pkg::entry_type     entry,
   output logic                    keep
);
   import bsps_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Stay in place when occupied and not strictly below the new quantity.
   assign keep  = occupied && !(entry_ff.qty < new_entry.qty);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ src/bounded_stable_priority_stack.sv @@
`timescale 1ns / 1ps
// Top level of the bounded stable priority stack: request/response channels,
// entry count, response register and the chain of bsps_cell slots.
// Depends on bsps_pkg, bsps_req_if, bsps_rsp_if and bsps_cell.
//
//   channel  direction  payload                                   handshake
//   req_ch   in         operation, entry_id, entry_qty            valid/ready
//   rsp_ch   out        head_id, head_qty, status, occupancy      valid/ready
//
// Cycles: one item per clock unless the response stalls. The whole chain updates
// at the accept edge; the result is registered there and offered the next cycle.
// The path that sets the clock is the 32-bit quantity compare in every cell
// feeding its own three-way entry select.
// Reset: synchronous, clears the entry count and the response valid; slot
// contents are not cleared and there is no clearing pass. No item is taken
// while reset is high.
// Stalls: a new item is taken whenever the response register is empty or is
// being drained in the same cycle.
module bounded_stable_priority_stack (
   input  logic        clock,
   input  logic        reset,
   bsps_req_if.sink    req_ch,
   bsps_rsp_if.source  rsp_ch
);
   import bsps_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [ID_W-1:0]   rsp_id_in;
   logic [QTY_W-1:0]  rsp_qty_ff;
   logic [QTY_W-1:0]  rsp_qty_in;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [ST_W-1:0]   rsp_status_in;
   logic [OCC_W-1:0]  rsp_occ_ff;
   logic [OCC_W-1:0]  rsp_occ_in;

   logic          req_fire;
   logic          is_empty;
   logic          is_full;
   shift_ctl_type ctl;
   entry_type     new_entry;

   entry_type cell_q    [DEPTH];
   entry_type prev_e    [DEPTH];
   entry_type next_e    [DEPTH];
   logic      cell_keep [DEPTH];
   logic      prev_k    [DEPTH];
   logic      occ       [DEPTH];

   // Take a new item when out of reset and the response slot is free or draining.
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));

   assign new_entry.id  = req_ch.entry_id;
   assign new_entry.qty = req_ch.entry_qty;

   // Broadcast control to every slot; skip the shift on a pop of an empty stack.
   assign ctl.insert = req_fire && (req_ch.operation == OP_INSERT);
   assign ctl.pop    = req_fire && (req_ch.operation == OP_POP) && !is_empty;

   // Chain wiring: the head takes the new entry whenever it does not keep its
   // own; the tail pulls nothing meaningful on pop since the count excludes it.
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_chain
         assign occ[gi] = (count_ff > CNT_W'(gi));
         if (gi == 0) begin : g_head
            assign prev_e[gi] = new_entry;
            assign prev_k[gi] = 1'b1;
         end else begin : g_body
            assign prev_e[gi] = cell_q[gi-1];
            assign prev_k[gi] = cell_keep[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign next_e[gi] = '0;
         end else begin : g_inner
            assign next_e[gi] = cell_q[gi+1];
         end

         bsps_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .prev_entry (prev_e[gi]),
            .next_entry (next_e[gi]),
            .prev_keep  (prev_k[gi]),
            .occupied   (occ[gi]),
            .entry      (cell_q[gi]),
            .keep       (cell_keep[gi])
         );
      end
   endgenerate

   // Count and response: compute both from the state before the accept edge.
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = '0;
         rsp_qty_in    = '0;
         rsp_status_in = ST_OK;
         case (req_ch.operation)
            OP_INSERT: begin
               if (is_full) begin
                  // Drop the lowest-ranked entry, possibly the new one.
                  rsp_status_in = ST_OVERFLOW;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP, OP_PEEK: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_id_in  = cell_q[0].id;
                  rsp_qty_in = cell_q[0].qty;
                  if (req_ch.operation == OP_POP) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               // Unused code: report status OK, zero head fields and the occupancy; change nothing.
            end
         endcase
         rsp_occ_in = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_id_ff     <= rsp_id_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.head_id   = rsp_id_ff;
   assign rsp_ch.head_qty  = rsp_qty_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.occupancy = rsp_occ_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.insert && !is_full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert into non-full stack did not grow count");

   a_empty_pop_holds: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.operation == OP_POP && is_empty |=> count_ff == '0)
      else $error("pop on empty stack changed count");

   a_head_ordered: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> !(cell_q[0].qty < cell_q[1].qty))
      else $error("head slots out of order");

   a_no_take_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_fire)
      else $error("item taken while response stalled");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the bounded stable priority stack: drives requests, tracks
// the sorted store on the side and checks every response in order.
// Depends on bsps_pkg, bsps_req_if, bsps_rsp_if and the bounded_stable_priority_stack RTL.

import bsps_pkg::*;

localparam logic [OP_W-1:0] OP_NONE = 2'd3;

typedef struct packed {
   logic        [ID_W-1:0]  id;
   logic signed [QTY_W-1:0] qty;
   logic        [ST_W-1:0]  status;
   logic        [OCC_W-1:0] occupancy;
} result_type;

// Side copy of the sorted store plus the responses it still owes.
class ranked_store_board;
   entry_type  slots[DEPTH];
   int         count;
   result_type due_results[$];
   int         errors;
   int         received;

   function new();
      count    = 0;
      errors   = 0;
      received = 0;
   endfunction

   function int pending();
      return due_results.size();
   endfunction

   // Apply one accepted request to the store and queue the response it owes.
   function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic signed [QTY_W-1:0] qty);
      result_type want;
      int         pos;
      want = '0;
      want.status = ST_OK;
      if (op == OP_INSERT) begin
         pos = 0;
         // Stay below every entry of greater or equal quantity.
         while (pos < count && $signed(slots[pos].qty) >= $signed(qty))
            pos++;
         if (count >= DEPTH) begin
            want.status = ST_OVERFLOW;
            // A new entry that ranks last is the one dropped.
            if (pos < DEPTH) begin
               for (int i = DEPTH - 1; i > pos; i--)
                  slots[i] = slots[i-1];
               slots[pos].id  = id;
               slots[pos].qty = qty;
            end
         end else begin
            for (int i = count; i > pos; i--)
               slots[i] = slots[i-1];
            slots[pos].id  = id;
            slots[pos].qty = qty;
            count++;
         end
      end else if (op == OP_POP || op == OP_PEEK) begin
         if (count == 0) begin
            want.status = ST_EMPTY;
         end else begin
            want.id  = slots[0].id;
            want.qty = slots[0].qty;
            if (op == OP_POP) begin
               for (int i = 1; i < count; i++)
                  slots[i-1] = slots[i];
               count--;
            end
         end
      end
      want.occupancy = OCC_W'(count);
      due_results.push_back(want);
   endfunction

   function void match(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   function void check_response(result_type got);
      result_type want;
      received++;
      if (due_results.size() == 0) begin
         $display("%0t ns: unexpected response: expected none, actual %0h/%0h/%0h/%0h",
                  $time, got.id, got.qty, got.status, got.occupancy);
         errors++;
      end else begin
         want = due_results.pop_front();
         match("head_id",   64'(want.id),        64'(got.id));
         match("head_qty",  64'(want.qty),       64'(got.qty));
         match("status",    64'(want.status),    64'(got.status));
         match("occupancy", 64'(want.occupancy), 64'(got.occupancy));
      end
   endfunction
endclass

module tb;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 160;
   localparam int HOLD_AFTER   = 400;
   localparam int DRAIN_CYCLES = 4;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic clock;
   logic reset;
   int   cycle_count;

   ranked_store_board board;

   // Idle-run state for each side: a run of items either all back to back or
   // each with a random gap.
   int send_run;
   bit send_quiet;
   int take_run;
   bit take_quiet;
   bit held_off;

   bsps_req_if req_bus ();
   bsps_rsp_if rsp_bus ();

   bounded_stable_priority_stack DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watchdog: end the run with an error once the cycle limit is reached.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Draw the wait before the next item; start a fresh run when the old one is used up.
   function automatic int draw_gap(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         quiet    = ($urandom_range(0, 3) == 0);
         run_left = $urandom_range(5, 40);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 17);
   endfunction

   // Quantities: often a narrow band so ties are common, some extremes, and mostly
   // fully random patterns.
   function automatic logic signed [QTY_W-1:0] pick_qty();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return QTY_W'(int'($urandom_range(0, 6)) - 3);
         4: begin
            case ($urandom_range(0, 6))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh7FFF_FFFE;
               3: return 32'sh8000_0001;
               4: return 32'sd0;
               5: return 32'sd1;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Weight the operation by the current mix so the store both fills up and drains.
   function automatic logic [OP_W-1:0] pick_op(mix_type mix);
      int roll;
      int ins_pct;
      int pop_pct;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            ins_pct = 80;
            pop_pct = 8;
         end
         MIX_DRAIN: begin
            ins_pct = 25;
            pop_pct = 60;
         end
         default: begin
            ins_pct = 45;
            pop_pct = 35;
         end
      endcase
      if (roll < ins_pct)
         return OP_INSERT;
      if (roll < ins_pct + pop_pct)
         return OP_POP;
      if (roll < 96)
         return OP_PEEK;
      return OP_NONE;
   endfunction

   // Offer one item after its gap and hold it until the block takes it.
   task automatic offer(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                        input logic signed [QTY_W-1:0] qty);
      int gap;
      gap = draw_gap(send_run, send_quiet);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.entry_id  = id;
      req_bus.entry_qty = qty;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      board.note_request(op, id, qty);
      @(negedge clock);
   endtask

   // Reset: start high, drop it at a falling edge.
   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Response side: take each item after a random stall; once in the run,
   // hold off for a long stretch so the block backs up and stalls its input.
   initial begin : take_responses
      int         gap;
      result_type got;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = draw_gap(take_run, take_quiet);
         if (!held_off && board.received == HOLD_AFTER) begin
            gap      = HOLD_CYCLES;
            held_off = 1'b1;
         end
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do
            @(posedge clock);
         while (rsp_bus.valid !== 1'b1);
         got.id        = rsp_bus.head_id;
         got.qty       = rsp_bus.head_qty;
         got.status    = rsp_bus.status;
         got.occupancy = rsp_bus.occupancy;
         board.check_response(got);
         @(negedge clock);
      end
   end

   initial begin : run_requests
      mix_type mix;
      int      mix_left;
      logic [OP_W-1:0] op;
      board       = new();
      cycle_count = 0;
      send_run    = 0;
      send_quiet  = 1'b0;
      take_run    = 0;
      take_quiet  = 1'b0;
      held_off    = 1'b0;

      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INSERT;
      req_bus.entry_id  = '0;
      req_bus.entry_qty = '0;
      wait (reset == 1'b0);
      @(negedge clock);

      // Directed: empty store, the unused code, extreme fields, ties, then drain.
      offer(OP_POP,    16'h0000, 32'sd0);
      offer(OP_PEEK,   16'hFFFF, 32'shFFFF_FFFF);
      offer(OP_NONE,   16'hA5A5, 32'sh5A5A_5A5A);
      offer(OP_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
      offer(OP_INSERT, 16'h0000, 32'sh8000_0000);
      offer(OP_INSERT, 16'h0001, 32'sd0);
      offer(OP_INSERT, 16'h0002, -32'sd1);
      offer(OP_INSERT, 16'h0003, 32'sd0);           // tie: lands below the older zero
      offer(OP_INSERT, 16'h0004, 32'sh7FFF_FFFF);   // tie with the head
      offer(OP_PEEK,   16'h1234, 32'sh1234_5678);
      offer(OP_NONE,   16'h0000, 32'sd0);
      offer(OP_POP,    16'hFFFF, 32'sh7FFF_FFFF);   // fields ignored on pop
      offer(OP_PEEK,   16'h0000, 32'sd0);
      offer(OP_POP,    16'h0000, 32'sd0);
      offer(OP_INSERT, 16'h8000, 32'sh8000_0000);   // tie at the bottom
      offer(OP_POP,    16'h0000, 32'sd0);
      offer(OP_POP,    16'h0000, 32'sd0);
      offer(OP_POP,    16'h0000, 32'sd0);
      offer(OP_POP,    16'h0000, 32'sd0);
      offer(OP_POP,    16'h0000, 32'sd0);
      offer(OP_POP,    16'h0000, 32'sd0);           // empty again
      offer(OP_PEEK,   16'h0000, 32'sd0);

      // Random: mixes alternate in blocks, starting with a fill so the store
      // reaches its limit and overflows early.
      mix      = MIX_FILL;
      mix_left = 150;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (mix_left == 0) begin
            mix      = mix_type'($urandom_range(0, 2));
            mix_left = $urandom_range(40, 160);
         end
         mix_left--;
         op = pick_op(mix);
         offer(op, 16'($urandom()), pick_qty());
      end
      req_bus.valid = 1'b0;

      // Drain: wait for every owed response, then a few cycles for strays.
      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
